>>> hdl/pwrm_pkg.sv
// Package: shared types and constants of the phase window running mean block.
`timescale 1ns / 1ps
package pwrm_pkg;

  localparam int PHASE_W  = 40;
  localparam int SAMPLE_W = 32;
  localparam int STEP_W   = 28;
  localparam int WIN_W    = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [WIN_W-1:0] WIN_RESET = 32'd105414357;

  localparam logic REG_WINDOW = 1'b0;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [SAMPLE_W-1:0] sample;
  } ring_entry_t;

  localparam int ENTRY_W = PHASE_W + SAMPLE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL_EV,
    ST_STORE,
    ST_CHK,
    ST_CHK_WAIT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> hdl/pwrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pwrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/phase_window_running_mean_top.sv
// Top level: phase window running mean with ring buffer and serial divider.
// Per input: eviction if the ring is full, store, age checks with a wait after each
//   age eviction, then the divider and the result; the next input is taken once it is out.
// Throughput: one item at a time, set by the 38-step restoring divider and result stalls.
// Synchronous active-low reset clears phase, sum, pointers, fill count and window to 2*pi.
// Ring contents are not cleared; only held entries are read.
`timescale 1ns / 1ps
module phase_window_running_mean_top #(
  parameter int RING_DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [pwrm_pkg::SAMPLE_W-1:0]           in_bmag,
  input  logic signed [pwrm_pkg::STEP_W-1:0]      in_phase_step,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [pwrm_pkg::SAMPLE_W-1:0]           out_mean,
  output logic [$clog2(RING_DEPTH+1)-1:0]         out_held,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [pwrm_pkg::CFG_AW-1:0]             paddr,
  input  logic [pwrm_pkg::CFG_DW-1:0]             pwdata,
  output logic [pwrm_pkg::CFG_DW-1:0]             prdata,
  output logic                                    pready
);
  import pwrm_pkg::*;

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + ADDR_W;
  localparam int DCNT_W = $clog2(SUM_W);

  state_t state_r, state_nxt;

  logic [WIN_W-1:0]    window_r;
  logic [PHASE_W-1:0]  phase_now_r, phase_now_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   wr_r, wr_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [SUM_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_mean_r, out_mean_nxt;
  logic [CNT_W-1:0]    out_held_r, out_held_nxt;

  logic        ram_we;
  ring_entry_t ram_wdata;
  ring_entry_t ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic                in_xfer;
  logic                cfg_wr;
  logic                full;
  logic                multi;
  logic [PHASE_W-1:0]  age;
  logic                too_old;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      trial_diff;
  logic                trial_ge;
  logic                out_free;

  pwrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = ring_entry_t'(ram_rdata_raw);

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;
  assign out_held  = out_held_r;
  assign out_free  = !out_valid_r || out_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
  assign prdata = (paddr[2] == REG_WINDOW) ? window_r : '0;

  assign full    = (fill_r == CNT_W'(RING_DEPTH));
  assign multi   = (fill_r > CNT_W'(1));
  assign age     = phase_now_r - ram_rdata.phase;
  assign too_old = !age[PHASE_W-1] && (age > {{(PHASE_W-WIN_W){1'b0}}, window_r});

  assign trial      = {rem_r, q_r[SUM_W-1]};
  assign trial_diff = trial - {1'b0, fill_r};
  assign trial_ge   = (trial >= {1'b0, fill_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = full ? ST_FULL_EV : ST_STORE;
        end
      end
      ST_FULL_EV:  state_nxt = ST_STORE;
      ST_STORE:    state_nxt = ST_CHK;
      ST_CHK:      state_nxt = (multi && too_old) ? ST_CHK_WAIT : ST_DIV;
      ST_CHK_WAIT: state_nxt = ST_CHK;
      ST_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_now_nxt    = phase_now_r;
    sample_nxt       = sample_r;
    sum_nxt          = sum_r;
    head_nxt         = head_r;
    wr_nxt           = wr_r;
    fill_nxt         = fill_r;
    q_nxt            = q_r;
    rem_nxt          = rem_r;
    dcnt_nxt         = dcnt_r;
    out_mean_nxt     = out_mean_r;
    out_held_nxt     = out_held_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    ram_we           = 1'b0;
    ram_wdata.phase  = phase_now_r;
    ram_wdata.sample = sample_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          phase_now_nxt = phase_now_r + PHASE_W'(in_phase_step);
          sample_nxt    = in_bmag;
        end
      end
      ST_FULL_EV: begin
        sum_nxt  = sum_r - SUM_W'(ram_rdata.sample);
        fill_nxt = fill_r - CNT_W'(1);
        head_nxt = (head_r == ADDR_W'(RING_DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);
      end
      ST_STORE: begin
        ram_we   = 1'b1;
        sum_nxt  = sum_r + SUM_W'(sample_r);
        fill_nxt = fill_r + CNT_W'(1);
        wr_nxt   = (wr_r == ADDR_W'(RING_DEPTH - 1)) ? '0 : wr_r + ADDR_W'(1);
      end
      ST_CHK: begin
        if (multi && too_old) begin
          sum_nxt  = sum_r - SUM_W'(ram_rdata.sample);
          fill_nxt = fill_r - CNT_W'(1);
          head_nxt = (head_r == ADDR_W'(RING_DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);
        end else begin
          q_nxt    = sum_r;
          rem_nxt  = '0;
          dcnt_nxt = DCNT_W'(SUM_W - 1);
        end
      end
      ST_CHK_WAIT: begin
      end
      ST_DIV: begin
        q_nxt    = {q_r[SUM_W-2:0], trial_ge};
        rem_nxt  = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dcnt_nxt = dcnt_r - DCNT_W'(1);
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = q_r[SAMPLE_W-1:0];
          out_held_nxt  = fill_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WIN_RESET;
      phase_now_r <= '0;
      sum_r       <= '0;
      head_r      <= '0;
      wr_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_now_r <= phase_now_nxt;
      sum_r       <= sum_nxt;
      head_r      <= head_nxt;
      wr_r        <= wr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        window_r <= pwdata[WIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    out_mean_r <= out_mean_nxt;
    out_held_r <= out_held_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(RING_DEPTH))
    else $error("fill count above ring depth");

  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (head_r == wr_r && sum_r == '0))
    else $error("empty ring with nonzero sum or pointer skew");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (fill_r != '0))
    else $error("divide with zero count");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_held_r != '0))
    else $error("result transfer with zero held count");

endmodule

>>> tb/phase_window_running_mean_checker.sv
// Checker: predicts the windowed mean of each transfer and compares the block's results.
`timescale 1ns / 1ps
module phase_window_running_mean_checker #(
  parameter int RING_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [pwrm_pkg::SAMPLE_W-1:0]         in_bmag,
  input  logic signed [pwrm_pkg::STEP_W-1:0]    in_phase_step,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [pwrm_pkg::SAMPLE_W-1:0]         out_mean,
  input  logic [$clog2(RING_DEPTH+1)-1:0]       out_held,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pwrm_pkg::CFG_AW-1:0]           paddr,
  input  logic [pwrm_pkg::CFG_DW-1:0]           pwdata,
  input  logic                                  pready,
  output int                                    outstanding,
  output int                                    fail_count
);
  import pwrm_pkg::*;

  localparam int HELD_W = $clog2(RING_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [HELD_W-1:0]   held;
  } mean_result_t;

  logic [WIN_W-1:0]    win;
  logic [PHASE_W-1:0]  phase_acc;
  logic [PHASE_W-1:0]  phase_hist [RING_DEPTH];
  logic [SAMPLE_W-1:0] sample_hist [RING_DEPTH];
  logic [63:0]         sum;
  int unsigned         wr_slot;
  int unsigned         count;
  mean_result_t        mean_q [$];

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  function automatic void drop_oldest();
    int unsigned slot;
    slot  = (wr_slot + RING_DEPTH - count) % RING_DEPTH;
    sum   = sum - sample_hist[slot];
    count = count - 1;
  endfunction

  function automatic mean_result_t predict_mean(input logic [SAMPLE_W-1:0] bmag,
                                                input logic [STEP_W-1:0] step);
    logic [PHASE_W-1:0] age;
    int unsigned        slot;
    logic               aging;
    mean_result_t       res;
    phase_acc = phase_acc + {{(PHASE_W-STEP_W){step[STEP_W-1]}}, step};
    if (count >= RING_DEPTH) drop_oldest();
    phase_hist[wr_slot]  = phase_acc;
    sample_hist[wr_slot] = bmag;
    sum     = sum + bmag;
    wr_slot = (wr_slot + 1) % RING_DEPTH;
    count   = count + 1;
    aging   = 1'b1;
    while (aging && count > 1) begin
      slot = (wr_slot + RING_DEPTH - count) % RING_DEPTH;
      age  = phase_acc - phase_hist[slot];
      if (!age[PHASE_W-1] && age > PHASE_W'(win)) begin
        drop_oldest();
      end else begin
        aging = 1'b0;
      end
    end
    res.mean = SAMPLE_W'(sum / 64'(count));
    res.held = HELD_W'(count);
    return res;
  endfunction

  always @(posedge clk) begin
    mean_result_t want;
    logic         in_fire;
    logic         out_fire;
    in_fire  = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    if (!rst_n) begin
      win       = WIN_RESET;
      phase_acc = '0;
      sum       = '0;
      wr_slot   = 0;
      count     = 0;
      mean_q.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_AW-1:2] == REG_WINDOW) begin
        win = pwdata[WIN_W-1:0];
      end
      if (out_fire) begin
        if (mean_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: mean %0d held %0d", out_mean, out_held);
          end
          fail_count++;
        end else begin
          want = mean_q.pop_front();
          if (out_mean !== want.mean || out_held !== want.held) begin
            if (fail_count < 10) begin
              $display("mismatch: expected mean %0d held %0d, got mean %0d held %0d",
                       want.mean, want.held, out_mean, out_held);
            end
            fail_count++;
          end
        end
      end
      if (in_fire) mean_q.push_back(predict_mean(in_bmag, in_phase_step));
      outstanding <= outstanding + int'(in_fire) - int'(out_fire && mean_q.size() >= 0 &&
                                                        outstanding > 0);
    end
  end

endmodule

>>> tb/tb_phase_window_running_mean_top.sv
// Testbench top: clock, reset, stimulus, register writes and verdict for the running mean block.
`timescale 1ns / 1ps
module tb_phase_window_running_mean_top;
  import pwrm_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int HELD_W     = $clog2(RING_DEPTH + 1);

  localparam logic [CFG_AW-1:0] ADDR_WINDOW = CFG_AW'(REG_WINDOW) << 2;
  localparam logic [CFG_AW-1:0] ADDR_UNUSED = ADDR_WINDOW + CFG_AW'(4);

  localparam logic signed [STEP_W-1:0] STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};
  localparam logic signed [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0]      BMAG_MAX = '1;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 185;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [SAMPLE_W-1:0]         in_bmag;
  logic signed [STEP_W-1:0]    in_phase_step;
  logic                        out_valid;
  logic                        out_ready;
  logic [SAMPLE_W-1:0]         out_mean;
  logic [HELD_W-1:0]           out_held;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [CFG_AW-1:0]           paddr;
  logic [CFG_DW-1:0]           pwdata;
  logic [CFG_DW-1:0]           prdata;
  logic                        pready;
  int                          outstanding;
  int                          fail_count;
  bit                          calm;

  phase_window_running_mean_top #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_bmag      (in_bmag),
    .in_phase_step(in_phase_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_mean     (out_mean),
    .out_held     (out_held),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  phase_window_running_mean_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_bmag      (in_bmag),
    .in_phase_step(in_phase_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_mean     (out_mean),
    .out_held     (out_held),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #50000000;
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_bmag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return BMAG_MAX;
      2:       return SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [STEP_W-1:0] pick_step(input int lim);
    case ($urandom_range(0, 9))
      6:       return '0;
      7:       return -STEP_W'($urandom_range(0, lim));
      8:       return STEP_W'($urandom);
      9: begin
        case ($urandom_range(0, 3))
          0:       return STEP_MAX;
          1:       return STEP_MIN;
          2:       return STEP_W'(1);
          default: return -STEP_W'(1);
        endcase
      end
      default: return STEP_W'($urandom_range(0, lim));
    endcase
  endfunction

  // hold out_ready low for a random stretch, then high for a random stretch
  initial begin
    int low_len;
    int high_len;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      low_len = pick_gap();
      if (low_len > 0) begin
        out_ready <= 1'b0;
        repeat (low_len) @(posedge clk);
      end
      out_ready <= 1'b1;
      high_len = $urandom_range(1, 8);
      repeat (high_len) @(posedge clk);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] bmag,
                             input logic signed [STEP_W-1:0] step, input int gap);
    logic taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_bmag       <= bmag;
    in_phase_step <= step;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [WIN_W-1:0] win_v;
    longint           lim_q;
    int               lim;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_bmag       = '0;
    in_phase_step = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // extremes under the reset window, phase wrapping below zero
    send_sample(BMAG_MAX, '0, 0);
    send_sample('0, STEP_MAX, 1);
    send_sample(BMAG_MAX, STEP_MIN, 0);
    send_sample(BMAG_MAX, -STEP_W'(1), 2);
    send_sample(32'h8000_0000, STEP_MAX, 0);
    send_sample(BMAG_MAX, STEP_MAX, 0);

    // writes beyond the window register are dropped
    drain();
    write_reg(ADDR_UNUSED, '0);
    send_sample(32'd1, STEP_W'(1), 0);
    send_sample(32'd3, '0, 1);

    // zero window: a forward step ages out older entries behind the newest phase, stopping at the first that is not
    drain();
    write_reg(ADDR_WINDOW, '0);
    send_sample(32'd10, STEP_W'(1), 0);
    send_sample(32'd20, '0, 0);
    send_sample(32'd30, '0, 3);
    send_sample(32'd40, STEP_MIN, 0);
    send_sample(32'd50, STEP_W'(1), 0);
    send_sample(BMAG_MAX, STEP_MAX, 0);

    // widest window
    drain();
    write_reg(ADDR_WINDOW, '1);
    send_sample(BMAG_MAX, STEP_MAX, 0);
    send_sample(BMAG_MAX, STEP_MAX, 0);
    send_sample('0, STEP_MAX, 1);
    send_sample(32'h5555_5555, STEP_MIN, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       win_v = '1;
        1:       win_v = '0;
        2:       win_v = WIN_RESET;
        3:       win_v = WIN_W'(1);
        4:       win_v = WIN_W'($urandom);
        5:       win_v = WIN_W'($urandom_range(1000, 20000000));
        6:       win_v = '1;
        default: win_v = WIN_W'($urandom_range(0, 400000000));
      endcase
      drain();
      write_reg(ADDR_WINDOW, win_v);
      lim_q = longint'(win_v) / longint'($urandom_range(1, 70));
      if (p == 6) lim_q = $urandom_range(0, 5000);
      lim = (lim_q > longint'(STEP_MAX)) ? int'(STEP_MAX) : (lim_q == 0 ? 1 : int'(lim_q));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 30 == 0) calm = ($urandom_range(0, 4) == 0);
        if (i == ITEMS_PER_PHASE / 2) drain();
        send_sample(pick_bmag(), pick_step(lim), pick_gap());
      end
    end

    drain();
    repeat (250) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
